// ===== design/swq_pkg.sv =====
package swq_pkg;

	localparam int MaxProc = 16;
	localparam int KeyBits = 32;
	localparam int PW = $clog2(MaxProc);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_OUT    = 2'd2,
		OP_HEAD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] sem_key;
		logic [3:0]  proc_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] result_proc;
		logic       result_valid;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_WALK,
		S_DONE
	} state_t;

	// result of the descriptor scan
	typedef struct packed {
		logic          hit;
		logic [PW-1:0] hit_idx;
		logic          free;
		logic [PW-1:0] free_idx;
	} scan_t;

endpackage

// ===== design/swq_scan.sv =====
module swq_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        step,
	input  logic [swq_pkg::PW-1:0]      idx,
	input  logic                        in_use,
	input  logic [swq_pkg::KeyBits-1:0] key_a,
	input  logic [swq_pkg::KeyBits-1:0] key_b,
	output swq_pkg::scan_t              res
);
	import swq_pkg::*;

	scan_t res_q;

	// one compare per cycle while step is high, first match and first free kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else if (step) begin
			if (in_use && key_a == key_b && !res_q.hit) begin
				res_q.hit     <= 1'b1;
				res_q.hit_idx <= idx;
			end
			if (!in_use && !res_q.free) begin
				res_q.free     <= 1'b1;
				res_q.free_idx <= idx;
			end
		end
	end

	assign res = res_q;

endmodule

// ===== design/semaphore_wait_queue_table.sv =====
// semaphore wait-queue table
// command channel: drive cmd with start high while busy is low; that edge
// takes the beat. busy stays high while the command runs.
// result channel: rsp is shown for one cycle with done high; the receiver
// cannot stall it, so it must sample in that cycle.
// insert/remove/head first scan the descriptors after the accepting
// edge (one descriptor key compare per cycle in the shared comparator),
// then pass through a decide state and the done state.
// out_blocked skips the scan and goes from decide to done when the
// process is not blocked, otherwise it walks the queue one entry per
// step (up to MaxProc entries ahead of the process) before done.
// busy drops the cycle after done, so a new command is taken at the
// earliest in the cycle after the result. one command at a time.
// reset: all descriptors free and no process blocked; the result
// register is cleared. key, head, tail, link and owner tables are only
// read once written.
module semaphore_wait_queue_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  swq_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done,
	output swq_pkg::rsp_t  rsp
);
	import swq_pkg::*;

	// descriptor and process tables
	logic [MaxProc-1:0] desc_in_use_q;
	logic [MaxProc-1:0] proc_blk_q;
	logic [KeyBits-1:0] desc_key_q  [MaxProc];
	logic [PW-1:0]      desc_head_q [MaxProc];
	logic [PW-1:0]      desc_tail_q [MaxProc];
	logic [PW-1:0]      proc_next_q [MaxProc];
	logic [PW-1:0]      proc_desc_q [MaxProc];

	state_t state_q, state_d;
	op_t    op_q;
	logic [KeyBits-1:0] key_q;
	logic [PW-1:0]  p_q;
	logic [PW:0]    cnt_q;
	logic [PW-1:0]  d_q, cur_q, prev_q;
	logic           have_prev_q;
	rsp_t           rsp_q;

	scan_t scan;
	logic  scan_clear, scan_step;
	logic [PW-1:0] scan_idx;

	assign scan_idx   = cnt_q[PW-1:0];
	assign scan_clear = (state_q == S_IDLE);
	assign scan_step  = (state_q == S_SCAN);

	swq_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (scan_clear),
		.step   (scan_step),
		.idx    (scan_idx),
		.in_use (desc_in_use_q[scan_idx]),
		.key_a  (desc_key_q[scan_idx]),
		.key_b  (key_q),
		.res    (scan)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = (cmd.operation == OP_OUT) ? S_DECIDE : S_SCAN;
			S_SCAN:   if (cnt_q == (PW+1)'(MaxProc - 1)) state_d = S_DECIDE;
			S_DECIDE: state_d = (op_q == OP_OUT) ? S_WALK : S_DONE;
			S_WALK:   state_d = S_WALK;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
		if (state_q == S_WALK) begin
			// walk ends when process found, tail reached or steps exhausted
			if (cur_q == p_q || cur_q == desc_tail_q[d_q] || cnt_q == (PW+1)'(MaxProc))
				state_d = S_DONE;
		end
		if (state_q == S_DECIDE && op_q == OP_OUT) begin
			if (!proc_blk_q[p_q] || !desc_in_use_q[proc_desc_q[p_q]]) state_d = S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_in_use_q <= '0;
			proc_blk_q    <= '0;
			rsp_q         <= '0;
			cnt_q         <= '0;
			have_prev_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= op_t'(cmd.operation);
						key_q <= cmd.sem_key[KeyBits-1:0];
						p_q   <= cmd.proc_id[PW-1:0];
						cnt_q <= '0;
					end
				end
				S_SCAN: cnt_q <= cnt_q + 1'b1;
				S_DECIDE: begin
					unique case (op_q)
						OP_INSERT: begin
							if (proc_blk_q[p_q]) begin
								rsp_q <= '{status: ST_DUP, result_proc: '0,
									result_valid: 1'b0};
							end else if (!scan.hit && !scan.free) begin
								rsp_q <= '{status: ST_NOFREE, result_proc: '0,
									result_valid: 1'b0};
							end else begin
								rsp_q <= '{status: ST_OK, result_proc: '0,
									result_valid: 1'b0};
								if (scan.hit) begin
									proc_next_q[desc_tail_q[scan.hit_idx]] <= p_q;
									desc_tail_q[scan.hit_idx] <= p_q;
									proc_desc_q[p_q] <= scan.hit_idx;
								end else begin
									desc_in_use_q[scan.free_idx] <= 1'b1;
									desc_key_q[scan.free_idx]  <= key_q;
									desc_head_q[scan.free_idx] <= p_q;
									desc_tail_q[scan.free_idx] <= p_q;
									proc_desc_q[p_q] <= scan.free_idx;
								end
								proc_blk_q[p_q] <= 1'b1;
							end
						end
						OP_REMOVE, OP_HEAD: begin
							if (scan.hit) begin
								rsp_q <= '{status: ST_OK, result_valid: 1'b1,
									result_proc: 4'(desc_head_q[scan.hit_idx])};
								if (op_q == OP_REMOVE) begin
									if (desc_head_q[scan.hit_idx] == desc_tail_q[scan.hit_idx])
										desc_in_use_q[scan.hit_idx] <= 1'b0;
									else
										desc_head_q[scan.hit_idx] <=
											proc_next_q[desc_head_q[scan.hit_idx]];
									proc_blk_q[desc_head_q[scan.hit_idx]] <= 1'b0;
								end
							end else begin
								rsp_q <= '{status: ST_ABSENT, result_proc: '0,
									result_valid: 1'b0};
							end
						end
						OP_OUT: begin
							if (proc_blk_q[p_q] && desc_in_use_q[proc_desc_q[p_q]]) begin
								d_q         <= proc_desc_q[p_q];
								cur_q       <= desc_head_q[proc_desc_q[p_q]];
								have_prev_q <= 1'b0;
								cnt_q       <= '0;
							end else begin
								rsp_q <= '{status: ST_ABSENT, result_proc: '0,
									result_valid: 1'b0};
							end
						end
						default: ;
					endcase
				end
				S_WALK: begin
					if (cur_q == p_q) begin
						// unlink the found process
						rsp_q  <= '{status: ST_OK, result_valid: 1'b1,
							result_proc: 4'(p_q)};
						proc_blk_q[p_q] <= 1'b0;
						if (!have_prev_q) begin
							if (p_q == desc_tail_q[d_q]) desc_in_use_q[d_q] <= 1'b0;
							else desc_head_q[d_q] <= proc_next_q[p_q];
						end else begin
							if (p_q == desc_tail_q[d_q]) desc_tail_q[d_q] <= prev_q;
							else proc_next_q[prev_q] <= proc_next_q[p_q];
						end
					end else if (cur_q == desc_tail_q[d_q] || cnt_q == (PW+1)'(MaxProc)) begin
						rsp_q  <= '{status: ST_ABSENT, result_proc: '0, result_valid: 1'b0};
					end else begin
						prev_q      <= cur_q;
						have_prev_q <= 1'b1;
						cur_q       <= proc_next_q[cur_q];
						cnt_q       <= cnt_q + 1'b1;
					end
				end
				S_DONE: ;
				default: ;
			endcase
		end
	end

	// the result beat is shown during the single done-state cycle
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = rsp_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swq_pkg::*;

	localparam int NumRandom = 950;
	localparam int WatchLimit = 4000;
	localparam int MaxErrShow = 10;

	logic  clk;
	logic  arst_n;
	logic  start;
	cmd_t  cmd;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	semaphore_wait_queue_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// clock, 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the wait-queue table
	logic          mdl_in_use [MaxProc];
	logic [31:0]   mdl_key    [MaxProc];
	logic [PW-1:0] mdl_head   [MaxProc];
	logic [PW-1:0] mdl_tail   [MaxProc];
	logic [PW-1:0] mdl_next   [MaxProc];
	logic          mdl_blocked[MaxProc];
	logic [PW-1:0] mdl_owner  [MaxProc];

	rsp_t pending_rsp[$];
	int   mismatches;
	int   idle_count;

	// keys drawn from a small pool so queues actually share descriptors
	logic [31:0] key_pool[8];

	function automatic int find_key(logic [31:0] k);
		for (int d = 0; d < MaxProc; d++)
			if (mdl_in_use[d] && mdl_key[d] == k) return d;
		return -1;
	endfunction

	function automatic rsp_t mk_rsp(status_t st, logic [3:0] p, logic v);
		rsp_t r;
		r.status = st;
		r.result_proc = v ? p : 4'd0;
		r.result_valid = v;
		return r;
	endfunction

	// apply one command to the shadow table, return the expected beat
	function automatic rsp_t apply_cmd(cmd_t c);
		int d;
		int f;
		logic [PW-1:0] p;
		logic [PW-1:0] h;
		logic [PW-1:0] cur;
		logic [PW-1:0] prev;
		bit have_prev;
		bit found;
		p = c.proc_id[PW-1:0];
		case (op_t'(c.operation))
			OP_INSERT: begin
				if (mdl_blocked[p]) return mk_rsp(ST_DUP, 4'd0, 1'b0);
				d = find_key(c.sem_key);
				if (d < 0) begin
					f = -1;
					for (int i = MaxProc - 1; i >= 0; i--)
						if (!mdl_in_use[i]) f = i;
					if (f < 0) return mk_rsp(ST_NOFREE, 4'd0, 1'b0);
					d = f;
					mdl_in_use[d] = 1'b1;
					mdl_key[d] = c.sem_key;
					mdl_head[d] = p;
				end else begin
					mdl_next[mdl_tail[d]] = p;
				end
				mdl_tail[d] = p;
				mdl_blocked[p] = 1'b1;
				mdl_owner[p] = d[PW-1:0];
				return mk_rsp(ST_OK, 4'd0, 1'b0);
			end
			OP_REMOVE, OP_HEAD: begin
				d = find_key(c.sem_key);
				if (d < 0) return mk_rsp(ST_ABSENT, 4'd0, 1'b0);
				h = mdl_head[d];
				if (op_t'(c.operation) == OP_REMOVE) begin
					if (h == mdl_tail[d]) mdl_in_use[d] = 1'b0;
					else mdl_head[d] = mdl_next[h];
					mdl_blocked[h] = 1'b0;
				end
				return mk_rsp(ST_OK, h, 1'b1);
			end
			default: begin
				if (!mdl_blocked[p]) return mk_rsp(ST_ABSENT, 4'd0, 1'b0);
				d = mdl_owner[p];
				if (!mdl_in_use[d]) return mk_rsp(ST_ABSENT, 4'd0, 1'b0);
				cur = mdl_head[d];
				prev = '0;
				have_prev = 0;
				found = 0;
				for (int i = 0; i < MaxProc; i++) begin
					if (cur == p) begin
						found = 1;
						break;
					end
					if (cur == mdl_tail[d]) break;
					prev = cur;
					have_prev = 1;
					cur = mdl_next[cur];
				end
				if (!found) return mk_rsp(ST_ABSENT, 4'd0, 1'b0);
				if (!have_prev) begin
					if (p == mdl_tail[d]) mdl_in_use[d] = 1'b0;
					else mdl_head[d] = mdl_next[p];
				end else begin
					if (p == mdl_tail[d]) mdl_tail[d] = prev;
					else mdl_next[prev] = mdl_next[p];
				end
				mdl_blocked[p] = 1'b0;
				return mk_rsp(ST_OK, p, 1'b1);
			end
		endcase
	endfunction

	// result checker: done is a one-cycle strobe, sample at the edge
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxErrShow)
					$display("unexpected result beat: %p", rsp);
			end else begin
				rsp_t want;
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.result_proc !== want.result_proc
						|| rsp.result_valid !== want.result_valid) begin
					mismatches++;
					if (mismatches <= MaxErrShow)
						$display("mismatch: exp st=%0d proc=%0d v=%0d got st=%0d proc=%0d v=%0d",
							want.status, want.result_proc, want.result_valid,
							rsp.status, rsp.result_proc, rsp.result_valid);
				end
			end
		end
	end

	// watchdog: cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= WatchLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// one command beat; returns at the accepting edge with start still high
	task automatic send_cmd(cmd_t c, bit do_idle, bit has_want, rsp_t want);
		rsp_t pred;
		// random gap before the beat
		if (do_idle && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = apply_cmd(c);
		if (has_want && pred != want) begin
			mismatches++;
			if (mismatches <= MaxErrShow)
				$display("table entry disagrees with predictor for %p", c);
		end
		pending_rsp.push_back(pred);
	endtask

	typedef struct {
		op_t         op;
		logic [31:0] key;
		logic [3:0]  pid;
		bit          known;
		status_t     st;
		logic [3:0]  rp;
		logic        rv;
	} row_t;

	row_t directed[$];

	function automatic cmd_t pick_cmd();
		cmd_t c;
		int r;
		r = $urandom_range(99);
		// mostly well-formed traffic on a few keys, rest random noise
		c.sem_key = (r < 90) ? key_pool[$urandom_range(7)] : $urandom;
		c.proc_id = 4'($urandom_range(15));
		r = $urandom_range(99);
		if (r < 40) c.operation = OP_INSERT;
		else if (r < 65) c.operation = OP_REMOVE;
		else if (r < 85) c.operation = OP_OUT;
		else c.operation = OP_HEAD;
		return c;
	endfunction

	initial begin
		cmd_t c;
		rsp_t none;
		row_t rw;
		mismatches = 0;
		idle_count = 0;
		none = '0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		for (int i = 0; i < MaxProc; i++) begin
			mdl_in_use[i] = 0;
			mdl_blocked[i] = 0;
		end
		key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
			32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678, 32'h0000_0100};

		// directed table: empty table, extremes, error codes, mid-queue out
		directed = '{
			'{OP_REMOVE, 32'h0,         4'd0,  1, ST_ABSENT, 4'd0,  1'b0},
			'{OP_HEAD,   32'hFFFF_FFFF, 4'd0,  1, ST_ABSENT, 4'd0,  1'b0},
			'{OP_OUT,    32'h0,         4'd15, 1, ST_ABSENT, 4'd0,  1'b0},
			'{OP_INSERT, 32'hFFFF_FFFF, 4'd15, 1, ST_OK,     4'd0,  1'b0},
			'{OP_INSERT, 32'hFFFF_FFFF, 4'd15, 1, ST_DUP,    4'd0,  1'b0},
			'{OP_HEAD,   32'hFFFF_FFFF, 4'd0,  1, ST_OK,     4'd15, 1'b1},
			'{OP_INSERT, 32'hFFFF_FFFF, 4'd0,  0, ST_OK,     4'd0,  1'b0},
			'{OP_INSERT, 32'hFFFF_FFFF, 4'd7,  0, ST_OK,     4'd0,  1'b0},
			'{OP_OUT,    32'h0,         4'd0,  1, ST_OK,     4'd0,  1'b1},
			'{OP_OUT,    32'h0,         4'd7,  1, ST_OK,     4'd7,  1'b1},
			'{OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1, ST_OK,     4'd15, 1'b1},
			'{OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1, ST_ABSENT, 4'd0,  1'b0},
			'{OP_INSERT, 32'h0,         4'd3,  0, ST_OK,     4'd0,  1'b0},
			'{OP_INSERT, 32'h0,         4'd4,  0, ST_OK,     4'd0,  1'b0},
			'{OP_OUT,    32'h0,         4'd4,  0, ST_OK,     4'd0,  1'b0},
			'{OP_HEAD,   32'h0,         4'd0,  0, ST_OK,     4'd0,  1'b0}
		};
		// fill the pool with 15 more distinct keys, one process each (process 3 skipped)
		for (int i = 0; i < MaxProc; i++) begin
			rw = '{OP_INSERT, 32'h100 + i, 4'(i), 0, ST_OK, 4'd0, 1'b0};
			if (i != 3) directed.push_back(rw);
		end
		// process 3 is still blocked on key 0, so a new key is rejected
		directed.push_back('{OP_INSERT, 32'hDEAD_BEEF, 4'd3, 1, ST_DUP, 4'd0, 1'b0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			c.operation = directed[i].op;
			c.sem_key = directed[i].key;
			c.proc_id = directed[i].pid;
			send_cmd(c, 0, directed[i].known,
				mk_rsp(directed[i].st, directed[i].rp, directed[i].rv));
		end
		// full pool: pop process 3 from key 0, which frees its descriptor
		c = '{OP_REMOVE, 32'h0, 4'd0};
		send_cmd(c, 0, 0, none);
		// a fresh key takes the freed descriptor
		c = '{OP_INSERT, 32'hDEAD_BEEF, 4'd3};
		send_cmd(c, 0, 0, none);
		c = '{OP_OUT, 32'h0, 4'd5};
		send_cmd(c, 0, 0, none);
		c = '{OP_INSERT, 32'hCAFE_F00D, 4'd5};
		send_cmd(c, 0, 0, none);
		c = '{OP_OUT, 32'h0, 4'd6};
		send_cmd(c, 0, 0, none);
		// process 6 is free again and its descriptor is reused
		c = '{OP_INSERT, 32'h7777_7777, 4'd6};
		send_cmd(c, 0, 0, none);

		// random part; a stretch in the middle runs without gaps
		for (int n = 0; n < NumRandom; n++) begin
			c = pick_cmd();
			send_cmd(c, !(n >= 300 && n < 450), 0, none);
		end
		start <= 1'b0;

		// drain
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (3 * MaxProc + 10) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== semaphore_wait_queue_table.f =====
design/swq_pkg.sv
design/swq_scan.sv
design/semaphore_wait_queue_table.sv
tb/tb.sv
